// ----- hdl/liveness_buffer_slot_allocator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the buffer slot allocator
// Shorthand for the concurrent checks used by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef LIVENESS_BUFFER_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define LIVENESS_BUFFER_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Check that is switched off while reset is applied.
`define LBSA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Check that also holds across reset.
`define LBSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/lbsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Buffer slot allocator package
// Field widths, the slot table entry layout, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbsa_pkg;

  localparam int SHAPE_W    = 16;
  localparam int BYTES_W    = 40;
  localparam int TYPE_W     = 4;
  localparam int LAST_W     = 11;
  localparam int SLOT_OUT_W = 6;
  localparam int STEP_OUT_W = 10;
  localparam int SUM_W      = 48;

  // One slot table entry as stored in the RAM.
  typedef struct packed {
    logic [SHAPE_W-1:0] shape;
    logic [BYTES_W-1:0] bytes;
    logic [TYPE_W-1:0]  etype;
    logic [LAST_W-1:0]  free_after;
    logic               pinned;
  } lbsa_entry_t;

  localparam int ENTRY_W = $bits(lbsa_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } lbsa_state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
  } lbsa_cmd_t;

  typedef struct packed {
    logic match;
    logic scan_done;
    logic out_free;
  } lbsa_stat_t;

endpackage

// ----- hdl/lbsa_in_if.sv -----
// ----------------------------------------------------------------------------
// Allocator step request channel
// Valid/ready channel that carries one execution step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbsa_in_if import lbsa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      start_plan;
  logic [SHAPE_W-1:0]        shape_id;
  logic [BYTES_W-1:0]        size_bytes;
  logic [TYPE_W-1:0]         elem_type;
  logic                      is_output;
  logic signed [LAST_W-1:0]  last_read;

  modport source (
    output valid, start_plan, shape_id, size_bytes, elem_type, is_output, last_read,
    input  ready
  );

  modport sink (
    input  valid, start_plan, shape_id, size_bytes, elem_type, is_output, last_read,
    output ready
  );
endinterface

// ----- hdl/lbsa_out_if.sv -----
// ----------------------------------------------------------------------------
// Allocator result channel
// Valid/ready channel that carries one slot assignment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbsa_out_if import lbsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic                  reused;
  logic                  table_full;
  logic [STEP_OUT_W-1:0] step_num;
  logic [SUM_W-1:0]      naive_total;
  logic [SUM_W-1:0]      planned_total;

  modport source (
    output valid, slot_index, reused, table_full, step_num, naive_total, planned_total,
    input  ready
  );

  modport sink (
    input  valid, slot_index, reused, table_full, step_num, naive_total, planned_total,
    output ready
  );
endinterface

// ----- hdl/lbsa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- hdl/lbsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Buffer slot allocator controller
// Sequences accept, first-fit scan and commit of one step at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbsa_ctrl import lbsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lbsa_stat_t st,
  output lbsa_cmd_t  cmd
);

  lbsa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (st.match || st.scan_done) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = st.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/lbsa_datapath.sv -----
// ----------------------------------------------------------------------------
// Buffer slot allocator datapath
// Slot table RAM, pipelined first-fit compare, counters, saturating totals
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbsa_datapath import lbsa_pkg::*; #(
  parameter int MAX_SLOTS = 64,
  parameter int MAX_STEPS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lbsa_cmd_t                cmd,
  output lbsa_stat_t               st,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,
  input  logic                     in_start_plan,
  input  logic [SHAPE_W-1:0]       in_shape_id,
  input  logic [BYTES_W-1:0]       in_size_bytes,
  input  logic [TYPE_W-1:0]        in_elem_type,
  input  logic                     in_is_output,
  input  logic signed [LAST_W-1:0] in_last_read,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SLOT_OUT_W-1:0]    out_slot_index,
  output logic                     out_reused,
  output logic                     out_table_full,
  output logic [STEP_OUT_W-1:0]    out_step_num,
  output logic [SUM_W-1:0]         out_naive_total,
  output logic [SUM_W-1:0]         out_planned_total
);

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int STEP_W = $clog2(MAX_STEPS);
  localparam int CMP_W  = (STEP_W + 1 > LAST_W) ? STEP_W + 1 : LAST_W;

  // Latched step request.
  logic [SHAPE_W-1:0] shape_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [TYPE_W-1:0]  etype_r;
  logic               pin_r;
  logic [LAST_W-1:0]  last_r;

  logic               reuse_en_r;
  logic [CNT_W-1:0]   count_r;
  logic [STEP_W-1:0]  step_r;
  logic [SUM_W-1:0]   naive_r, naive_nxt;
  logic [SUM_W-1:0]   planned_r, planned_nxt;

  logic [CNT_W-1:0]   rd_addr_r;
  logic               cmp_valid_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic               out_valid_r;

  logic [ENTRY_W-1:0] ram_rdata;
  lbsa_entry_t        rd_entry, wr_entry;
  logic               issue;
  logic               match;
  logic signed [CMP_W-1:0] free_x, step_x;
  logic               full, open_slot;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   sel_idx;
  logic [IDX_W+SLOT_OUT_W-1:0]  slot_wide;
  logic [STEP_W+STEP_OUT_W-1:0] step_wide;
  logic [SUM_W:0]     naive_add, planned_add;

  assign rd_entry = lbsa_entry_t'(ram_rdata);

  // Reads run one slot ahead of the compare.
  assign issue = cmd.scan && reuse_en_r && (rd_addr_r < count_r);

  assign free_x = CMP_W'($signed(rd_entry.free_after));
  assign step_x = CMP_W'(step_r);

  assign match = cmp_valid_r && !rd_entry.pinned && (free_x < step_x) &&
                 (rd_entry.shape == shape_r) && (rd_entry.bytes == bytes_r) &&
                 (rd_entry.etype == etype_r);

  assign st.match     = match;
  assign st.scan_done = !issue && !cmp_valid_r;
  assign st.out_free  = !out_valid_r || out_ready;

  assign full      = !hit_r && (count_r == CNT_W'(MAX_SLOTS));
  assign open_slot = !hit_r && !full;

  // A reused slot already matches shape, size and type and was unpinned,
  // so the same word serves a reuse and a fresh slot.
  assign wr_entry.shape      = shape_r;
  assign wr_entry.bytes      = bytes_r;
  assign wr_entry.etype      = etype_r;
  assign wr_entry.free_after = last_r;
  assign wr_entry.pinned     = pin_r;

  assign ram_we    = cmd.commit && (hit_r || open_slot);
  assign ram_waddr = hit_r ? hit_idx_r : count_r[IDX_W-1:0];

  assign naive_add   = {1'b0, naive_r} + (SUM_W + 1)'(bytes_r);
  assign planned_add = {1'b0, planned_r} + (SUM_W + 1)'(bytes_r);
  assign naive_nxt   = naive_add[SUM_W] ? '1 : naive_add[SUM_W-1:0];
  assign planned_nxt = planned_add[SUM_W] ? '1 : planned_add[SUM_W-1:0];

  assign sel_idx   = full ? '0 : ram_waddr;
  assign slot_wide = {{SLOT_OUT_W{1'b0}}, sel_idx};
  assign step_wide = {{STEP_OUT_W{1'b0}}, step_r};

  lbsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (rd_addr_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reuse_en_r  <= 1'b1;
      count_r     <= '0;
      step_r      <= '0;
      naive_r     <= '0;
      planned_r   <= '0;
      rd_addr_r   <= '0;
      cmp_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) reuse_en_r <= cfg_wdata;

      if (cmd.accept) begin
        rd_addr_r   <= '0;
        cmp_valid_r <= 1'b0;
        hit_r       <= 1'b0;
        if (in_start_plan) begin
          count_r   <= '0;
          step_r    <= '0;
          naive_r   <= '0;
          planned_r <= '0;
        end
      end else if (cmd.scan) begin
        cmp_valid_r <= issue;
        if (issue) rd_addr_r <= rd_addr_r + 1'b1;
        if (match) hit_r <= 1'b1;
      end else begin
        cmp_valid_r <= 1'b0;
      end

      if (cmd.commit) begin
        naive_r <= naive_nxt;
        if (open_slot) begin
          count_r   <= count_r + 1'b1;
          planned_r <= planned_nxt;
        end
        if (step_r < STEP_W'(MAX_STEPS - 1)) step_r <= step_r + 1'b1;
      end

      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      shape_r <= in_shape_id;
      bytes_r <= in_size_bytes;
      etype_r <= in_elem_type;
      pin_r   <= in_is_output;
      last_r  <= in_last_read;
    end
    if (issue) cmp_idx_r <= rd_addr_r[IDX_W-1:0];
    if (cmd.scan && match) hit_idx_r <= cmp_idx_r;
    if (cmd.commit) begin
      out_slot_index    <= slot_wide[SLOT_OUT_W-1:0];
      out_reused        <= hit_r;
      out_table_full    <= full;
      out_step_num      <= step_wide[STEP_OUT_W-1:0];
      out_naive_total   <= naive_nxt;
      out_planned_total <= open_slot ? planned_nxt : planned_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/liveness_buffer_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Liveness-based first-fit buffer slot allocator
// A request is accepted, scanned and committed before the next one is taken in;
//   the scan reads one slot table RAM entry per cycle on its single read port.
// Reset: synchronous active-low rst_n; empty table, zero step index and
//   totals, reuse enabled. The table RAM itself needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block hands each step of a tensor plan a buffer slot. A request is
// latched, then the controller walks the slot table in order. The RAM read
// of slot i+1 overlaps the compare of slot i, and a walk that finds no hit
// ends once the scan has drained. The first slot that is unpinned, dead
// before this step, and equal in shape, size and element type ends the
// walk early. The commit cycle writes the table entry back (a reuse
// updates the last read and pin, a new slot writes the whole entry),
// bumps the counters, folds the byte size into the saturating totals
// and loads the result register.
//
// The result register sits between the datapath and the result channel, so
// a result may wait for the consumer while the next request is taken in.
// The commit of that next request waits only if the old result is still
// pending. Requests are taken one at a time: a new one is accepted only
// after the previous one has been committed.
//
// The reuse_enable register is written through cfg_we/cfg_wdata and is
// expected to change only while no request is in flight.

module liveness_buffer_slot_allocator_unit import lbsa_pkg::*; #(
  parameter int MAX_SLOTS = 64,
  parameter int MAX_STEPS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  lbsa_in_if.sink   in_ch,
  lbsa_out_if.source out_ch
);

  lbsa_cmd_t  cmd;
  lbsa_stat_t st;

  lbsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  lbsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .MAX_STEPS (MAX_STEPS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_start_plan     (in_ch.start_plan),
    .in_shape_id       (in_ch.shape_id),
    .in_size_bytes     (in_ch.size_bytes),
    .in_elem_type      (in_ch.elem_type),
    .in_is_output      (in_ch.is_output),
    .in_last_read      (in_ch.last_read),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_slot_index    (out_ch.slot_index),
    .out_reused        (out_ch.reused),
    .out_table_full    (out_ch.table_full),
    .out_step_num      (out_ch.step_num),
    .out_naive_total   (out_ch.naive_total),
    .out_planned_total (out_ch.planned_total)
  );

endmodule

// ----- hdl/lbsa_checker.sv -----
// ----------------------------------------------------------------------------
// Buffer slot allocator checker
// Port-level checks on the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "liveness_buffer_slot_allocator_unit_macros.svh"

module lbsa_checker import lbsa_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [SLOT_OUT_W-1:0] slot_index,
  input logic                  reused,
  input logic                  table_full,
  input logic [STEP_OUT_W-1:0] step_num,
  input logic [SUM_W-1:0]      naive_total,
  input logic [SUM_W-1:0]      planned_total
);

  logic [SLOT_OUT_W+STEP_OUT_W+2*SUM_W+1:0] payload;
  logic                                     out_stall;

  assign payload   = {slot_index, reused, table_full, step_num, naive_total, planned_total};
  assign out_stall = out_valid && !out_ready;

  // A stalled result keeps its payload.
  `LBSA_ASSERT(a_out_hold, clk, rst_n,
    out_stall |=> out_valid && $stable(payload), "result changed while stalled")

  // Requests are handled one at a time.
  `LBSA_ASSERT(a_one_in_flight, clk, rst_n,
    in_valid && in_ready |=> !in_ready, "request taken while another is in flight")

  // A full table never reports a reuse and always reports slot zero.
  `LBSA_ASSERT(a_full_result, clk, rst_n,
    out_valid && table_full |-> !reused && slot_index == '0, "table full result is inconsistent")

  // Planned bytes never exceed naive bytes.
  `LBSA_ASSERT(a_totals, clk, rst_n,
    out_valid |-> planned_total <= naive_total, "planned total above naive total")

  // No result is shown right after reset.
  `LBSA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind liveness_buffer_slot_allocator_unit lbsa_checker u_lbsa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .slot_index    (out_ch.slot_index),
  .reused        (out_ch.reused),
  .table_full    (out_ch.table_full),
  .step_num      (out_ch.step_num),
  .naive_total   (out_ch.naive_total),
  .planned_total (out_ch.planned_total)
);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Buffer slot allocator testbench
// Feeds tensor plan steps to the allocator through its request channel and
// checks every slot assignment against a built-in first-fit liveness model or a typed-in grant.
// A short table of directed steps comes first, then random plans under
// varying back-pressure and both settings of the reuse switch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import lbsa_pkg::*;;

  localparam int TABLE_SLOTS = 64;
  localparam int PLAN_STEPS  = 1024;
  localparam int CYCLE_LIMIT = 2000000;

  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
  localparam logic [LAST_W-1:0]  LR_NEVER  = 11'h7FF;  // -1
  localparam logic [LAST_W-1:0]  LR_MIN    = 11'h400;  // -1024
  localparam logic [LAST_W-1:0]  LR_MAX    = 11'h3FF;  // 1023

  // One request as it travels over the input channel.
  typedef struct packed {
    logic               start_plan;
    logic [SHAPE_W-1:0] shape_id;
    logic [BYTES_W-1:0] size_bytes;
    logic [TYPE_W-1:0]  elem_type;
    logic               is_output;
    logic [LAST_W-1:0]  last_read;
  } step_req_t;

  // One slot assignment as it comes back on the result channel.
  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  reused;
    logic                  table_full;
    logic [STEP_OUT_W-1:0] step_num;
    logic [SUM_W-1:0]      naive_total;
    logic [SUM_W-1:0]      planned_total;
  } slot_grant_t;

  typedef enum logic {
    ROW_STEP,
    ROW_CFG
  } row_kind_t;

  // A directed row is either a register write or a request. Where the
  // outcome is obvious the expected grant is typed in; otherwise the slot
  // model decides.
  typedef struct packed {
    row_kind_t   kind;
    logic        cfg_value;
    step_req_t   req;
    logic        typed;
    slot_grant_t grant;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 21;

  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Before any start_plan the plan left by reset continues: an empty table
    // opens slot 0 for a zero-sized step that is never read.
    '{ROW_STEP, 1'b0, '{1'b0, 16'h0000, 40'h0, 4'h0, 1'b0, LR_NEVER},
      1'b1, '{6'd0, 1'b0, 1'b0, 10'd0, 48'h0, 48'h0}},
    // The same shape again finds slot 0 dead and takes it over.
    '{ROW_STEP, 1'b0, '{1'b0, 16'h0000, 40'h0, 4'h0, 1'b0, 11'd5},
      1'b1, '{6'd0, 1'b1, 1'b0, 10'd1, 48'h0, 48'h0}},
    // A fresh plan with every field at its top value; the graph output pins
    // slot 0 for the rest of the plan.
    '{ROW_STEP, 1'b0, '{1'b1, 16'hFFFF, BYTES_MAX, 4'hF, 1'b1, LR_MAX},
      1'b1, '{6'd0, 1'b0, 1'b0, 10'd0, 48'h00FF_FFFF_FFFF, 48'h00FF_FFFF_FFFF}},
    // Pinned slot is skipped even though it matches, so slot 1 opens.
    '{ROW_STEP, 1'b0, '{1'b0, 16'hFFFF, BYTES_MAX, 4'hF, 1'b0, LR_MIN},
      1'b1, '{6'd1, 1'b0, 1'b0, 10'd1, 48'h01FF_FFFF_FFFE, 48'h01FF_FFFF_FFFE}},
    // Most negative last read frees slot 1 at once; this step's last read
    // lies before the step itself.
    '{ROW_STEP, 1'b0, '{1'b0, 16'hFFFF, BYTES_MAX, 4'hF, 1'b0, 11'd0}, 1'b0, '0},
    '{ROW_STEP, 1'b0, '{1'b0, 16'hFFFF, BYTES_MAX, 4'hF, 1'b0, 11'd4}, 1'b0, '0},
    // Slot 1 is read at this very step, so it is still live: a new slot.
    '{ROW_STEP, 1'b0, '{1'b0, 16'hFFFF, BYTES_MAX, 4'hF, 1'b0, 11'd10}, 1'b0, '0},
    // Near misses on shape and size each open a slot.
    '{ROW_STEP, 1'b0, '{1'b0, 16'h1234, BYTES_MAX, 4'hF, 1'b0, LR_NEVER}, 1'b0, '0},
    '{ROW_STEP, 1'b0, '{1'b0, 16'hFFFF, 40'h1, 4'hF, 1'b0, LR_NEVER}, 1'b0, '0},
    // A near miss on element type, with last read equal to the step that defines it.
    '{ROW_STEP, 1'b0, '{1'b0, 16'hFFFF, BYTES_MAX, 4'h0, 1'b0, 11'd7}, 1'b0, '0},
    '{ROW_STEP, 1'b0, '{1'b0, 16'hFFFF, BYTES_MAX, 4'h0, 1'b0, LR_NEVER}, 1'b0, '0},
    // With reuse switched off identical steps always open new slots.
    '{ROW_CFG, 1'b0, '0, 1'b0, '0},
    '{ROW_STEP, 1'b0, '{1'b1, 16'h00A5, 40'h64, 4'h3, 1'b0, LR_NEVER},
      1'b1, '{6'd0, 1'b0, 1'b0, 10'd0, 48'h64, 48'h64}},
    '{ROW_STEP, 1'b0, '{1'b0, 16'h00A5, 40'h64, 4'h3, 1'b0, LR_NEVER},
      1'b1, '{6'd1, 1'b0, 1'b0, 10'd1, 48'hC8, 48'hC8}},
    '{ROW_CFG, 1'b1, '0, 1'b0, '0},
    // Reuse back on: slot 0, then slot 0 pinned by a graph output, then the
    // allocator has to move on to slot 1.
    '{ROW_STEP, 1'b0, '{1'b0, 16'h00A5, 40'h64, 4'h3, 1'b0, LR_NEVER}, 1'b0, '0},
    '{ROW_STEP, 1'b0, '{1'b0, 16'h00A5, 40'h64, 4'h3, 1'b1, LR_NEVER}, 1'b0, '0},
    '{ROW_STEP, 1'b0, '{1'b0, 16'h00A5, 40'h64, 4'h3, 1'b0, LR_NEVER}, 1'b0, '0},
    // A negative last read other than -1 also means never read.
    '{ROW_STEP, 1'b0, '{1'b0, 16'h00A5, 40'h64, 4'h3, 1'b0, 11'h5A8}, 1'b0, '0},
    '{ROW_STEP, 1'b0, '{1'b0, 16'h00A5, 40'h64, 4'h3, 1'b0, LR_NEVER}, 1'b0, '0},
    '{ROW_STEP, 1'b0, '{1'b0, 16'h5A5A, 40'h0A_5A5A_5A5A, 4'hA, 1'b0, 11'h155},
      1'b0, '0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  lbsa_in_if  in_ch ();
  lbsa_out_if out_ch ();

  liveness_buffer_slot_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Slot table model. Entries at or above slot_count_q are never looked at,
  // so a new plan only has to drop the count.
  logic                reuse_q = 1'b1;
  int                  slot_count_q = 0;
  logic [SHAPE_W-1:0]  slot_shape_q [TABLE_SLOTS];
  logic [BYTES_W-1:0]  slot_bytes_q [TABLE_SLOTS];
  logic [TYPE_W-1:0]   slot_type_q [TABLE_SLOTS];
  int                  slot_free_after_q [TABLE_SLOTS];
  logic                slot_pinned_q [TABLE_SLOTS];
  int                  step_q = 0;
  logic [SUM_W-1:0]    naive_q = '0;
  logic [SUM_W-1:0]    planned_q = '0;

  // Grants the allocator still owes us, oldest first.
  slot_grant_t pending_grants [$];

  // Back-pressure knobs, in percent of cycles.
  int send_gap_pct = 0;
  int stall_pct = 0;

  int mismatches = 0;
  int steps_sent = 0;
  int grants_seen = 0;
  int reuse_seen = 0;
  int full_seen = 0;
  int plans_run = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  function automatic logic [SUM_W-1:0] sat48(logic [SUM_W-1:0] acc, logic [BYTES_W-1:0] add);
    logic [SUM_W:0] sum;
    sum = {1'b0, acc} + (SUM_W + 1)'(add);
    return sum[SUM_W] ? '1 : sum[SUM_W-1:0];
  endfunction

  // First-fit liveness allocation of one step; updates the table model and
  // returns the grant the allocator must report.
  function automatic slot_grant_t allocate_slot(step_req_t req);
    slot_grant_t grant;
    int last_rd;
    int pick;
    last_rd = int'($signed(req.last_read));
    if (req.start_plan) begin
      slot_count_q = 0;
      step_q = 0;
      naive_q = '0;
      planned_q = '0;
    end
    naive_q = sat48(naive_q, req.size_bytes);
    pick = -1;
    if (reuse_q) begin
      for (int i = 0; i < slot_count_q; i++) begin
        if (pick < 0 && !slot_pinned_q[i] && slot_free_after_q[i] < step_q &&
            slot_shape_q[i] == req.shape_id && slot_bytes_q[i] == req.size_bytes &&
            slot_type_q[i] == req.elem_type) begin
          pick = i;
        end
      end
    end
    grant = '0;
    if (pick >= 0) begin
      slot_free_after_q[pick] = last_rd;
      if (req.is_output) begin
        slot_pinned_q[pick] = 1'b1;
      end
      grant.slot_index = pick[SLOT_OUT_W-1:0];
      grant.reused = 1'b1;
    end else if (slot_count_q < TABLE_SLOTS) begin
      slot_shape_q[slot_count_q] = req.shape_id;
      slot_bytes_q[slot_count_q] = req.size_bytes;
      slot_type_q[slot_count_q] = req.elem_type;
      slot_free_after_q[slot_count_q] = last_rd;
      slot_pinned_q[slot_count_q] = req.is_output;
      grant.slot_index = slot_count_q[SLOT_OUT_W-1:0];
      slot_count_q++;
      planned_q = sat48(planned_q, req.size_bytes);
    end else begin
      grant.table_full = 1'b1;
    end
    grant.step_num = step_q[STEP_OUT_W-1:0];
    grant.naive_total = naive_q;
    grant.planned_total = planned_q;
    if (step_q < PLAN_STEPS - 1) begin
      step_q++;
    end
    return grant;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Free-running clock, 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a correct run finishes far below this count.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // The result side stalls at random; with stall_pct at zero it is always
  // ready.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Every accepted result is held against the oldest outstanding grant.
  // The values read here are the ones present at the clock edge, since all
  // drivers update them with nonblocking assignments.
  always @(posedge clk) begin
    slot_grant_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      grants_seen++;
      if (pending_grants.size() == 0) begin
        $error("result with no request outstanding: slot %0d, step %0d",
               out_ch.slot_index, out_ch.step_num);
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        check_field("slot_index", want.slot_index, out_ch.slot_index);
        check_field("reused", want.reused, out_ch.reused);
        check_field("table_full", want.table_full, out_ch.table_full);
        check_field("step_num", want.step_num, out_ch.step_num);
        check_field("naive_total", want.naive_total, out_ch.naive_total);
        check_field("planned_total", want.planned_total, out_ch.planned_total);
        reuse_seen += want.reused;
        full_seen += want.table_full;
      end
    end
  end

  // Offers one request and returns at the edge where it is taken. Valid is
  // left high so that a following request can go out back to back; every
  // path that does not send next lowers it at that same edge.
  task automatic send_step(step_req_t req, logic typed, slot_grant_t typed_grant);
    slot_grant_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.start_plan <= req.start_plan;
    in_ch.shape_id   <= req.shape_id;
    in_ch.size_bytes <= req.size_bytes;
    in_ch.elem_type  <= req.elem_type;
    in_ch.is_output  <= req.is_output;
    in_ch.last_read  <= req.last_read;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    // The model always advances; a typed-in grant, where present, is what
    // gets checked.
    predicted = allocate_slot(req);
    pending_grants.insert(pending_grants.size(), typed ? typed_grant : predicted);
    steps_sent++;
  endtask

  // Holds the request side until every outstanding grant has arrived.
  task automatic drain_requests();
    in_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The reuse switch may only change while nothing is in flight. Each
  // request yields exactly one grant, so an empty queue means idle; a few
  // spare cycles cover the result register hand-off.
  task automatic write_reuse(logic value);
    drain_requests();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reuse_q = value;
    cfg_writes++;
  endtask

  // One random plan. Most steps draw from a small pool of shape/size/type
  // tuples so that dead slots get matched and reused; the rest are noise.
  // Last reads mostly sit a few steps ahead, so slots keep dying and coming
  // back. A plan started without start_plan carries on the previous one.
  task automatic run_plan(int length, logic fresh);
    logic [SHAPE_W-1:0] pool_shape [8];
    logic [BYTES_W-1:0] pool_bytes [8];
    logic [TYPE_W-1:0]  pool_type [8];
    int pool_n;
    int pos;
    int pick;
    int roll;
    int lr;
    step_req_t req;
    pool_n = $urandom_range(1, 6);
    for (int k = 0; k < pool_n; k++) begin
      // Some tuples share a shape but differ in size or type.
      pool_shape[k] = (k > 0 && $urandom_range(0, 3) == 0) ? pool_shape[0] : 16'($urandom);
      pool_bytes[k] = {8'($urandom), 32'($urandom)};
      pool_type[k]  = 4'($urandom);
    end
    for (int i = 0; i < length; i++) begin
      pos = (i < PLAN_STEPS) ? i : PLAN_STEPS - 1;
      req.start_plan = fresh && (i == 0);
      if ($urandom_range(0, 99) < 85) begin
        pick = $urandom_range(0, pool_n - 1);
        req.shape_id   = pool_shape[pick];
        req.size_bytes = pool_bytes[pick];
        req.elem_type  = pool_type[pick];
      end else begin
        req.shape_id   = 16'($urandom);
        req.size_bytes = {8'($urandom), 32'($urandom)};
        req.elem_type  = 4'($urandom);
      end
      req.is_output = ($urandom_range(0, 99) < 8);
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        lr = pos + $urandom_range(0, 5);
        lr = (lr > PLAN_STEPS - 1) ? PLAN_STEPS - 1 : lr;
      end else if (roll < 72) begin
        lr = -1;
      end else if (roll < 82) begin
        lr = pos - $urandom_range(0, 3);
      end else begin
        lr = int'($signed(11'($urandom)));
      end
      req.last_read = 11'(lr);
      send_step(req, 1'b0, '0);
      // Now and then let the pipeline run dry in the middle of a plan.
      if ($urandom_range(0, 99) < 2) begin
        drain_requests();
      end
    end
    plans_run++;
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.start_plan = 1'b0;
    in_ch.shape_id   = '0;
    in_ch.size_bytes = '0;
    in_ch.elem_type  = '0;
    in_ch.is_output  = 1'b0;
    in_ch.last_read  = '0;
    out_ch.ready     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, walked in order, starting with reuse at its reset value.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_reuse(DIRECTED[r].cfg_value);
      end else begin
        send_step(DIRECTED[r].req, DIRECTED[r].typed, DIRECTED[r].grant);
      end
    end

    // Reuse on; sender rarely idles, the result side stalls most cycles.
    // One plan skips start_plan and runs on from the one before.
    write_reuse(1'b1);
    send_gap_pct = 7;
    stall_pct = 68;
    for (int p = 0; p < 20; p++) begin
      run_plan($urandom_range(3, 40), p != 6);
    end

    // Reuse off, roles swapped. The long plan overruns the slot table.
    write_reuse(1'b0);
    send_gap_pct = 68;
    stall_pct = 7;
    for (int p = 0; p < 3; p++) begin
      run_plan($urandom_range(20, 40), 1'b1);
    end
    run_plan(75, 1'b1);

    // Reuse on at full speed. The first plan runs past the step limit, fills
    // the table through its noise steps and saturates the naive total.
    write_reuse(1'b1);
    send_gap_pct = 0;
    stall_pct = 0;
    run_plan(1040, 1'b1);
    for (int p = 0; p < 8; p++) begin
      run_plan($urandom_range(3, 40), 1'b1);
    end

    drain_requests();
    repeat (10) @(posedge clk);
    $display("Sent %0d steps in %0d random plans plus the directed table, %0d reuse writes.",
             steps_sent, plans_run, cfg_writes);
    $display("Checked %0d grants: %0d reused a slot, %0d hit a full table.",
             grants_seen, reuse_seen, full_seen);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
